### rtl/tnps_pkg.sv
// Shared types, operation codes and the sigmoid lookup table of the pair scorer.
// No dependencies; every other file imports this package.
package tnps_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ROW  = 2'd1,
      OP_COL  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   // operand A source and operand B source of one multiply-accumulate beat
   typedef enum logic [1:0] {
      ASEL_ZERO = 2'd0,
      ASEL_WMEM = 2'd1,
      ASEL_PMEM = 2'd2,
      ASEL_RSVD = 2'd3
   } asel_type;

   typedef enum logic [1:0] {
      BSEL_NONE = 2'd0,
      BSEL_ROW  = 2'd1,
      BSEL_COL  = 2'd2,
      BSEL_PMEM = 2'd3
   } bsel_type;

   typedef struct packed {
      logic valid;
      logic init;   // load operand A into the accumulator
      logic last;   // final beat of a sum
      logic relu;
      logic fin;    // sum is the network output
   } beat_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic fin;
      logic sat;    // any clamp since the last clear, this beat included
   } mac_res_type;

   localparam logic signed [DATA_W-1:0] SIG_LO = -32'sd524288;
   localparam logic signed [DATA_W-1:0] SIG_HI = 32'sd524288;
   localparam logic [63:0] EXP_STEP = 64'd4034748382;

   typedef logic [15:0] sig_table_type [256];

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic [63:0] p [129];
      logic [63:0] s [129];
      logic [127:0] prod;
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] q;
      logic [63:0] neg;
      int k;
      int i;
      int b;
      p[0] = 64'h1_0000_0000;
      for (k = 1; k <= 128; k++) begin
         prod = 128'(p[k-1]) * 128'(EXP_STEP) + (128'd1 << 31);
         p[k] = prod[95:32];
      end
      for (k = 0; k <= 128; k++) begin
         d   = 64'h1_0000_0000 + p[k];
         num = (64'd1 << 48) + (d >> 1);
         rem = '0;
         q   = '0;
         for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            q   = q << 1;
            if (rem >= d) begin
               rem  = rem - d;
               q[0] = 1'b1;
            end
         end
         s[k] = q;
      end
      for (i = 0; i < 256; i++) begin
         if (i >= 128) begin
            t[i] = (s[i-128] > 64'd65535) ? 16'hFFFF : s[i-128][15:0];
         end else begin
            neg  = 64'd65536 - s[128-i];
            t[i] = neg[15:0];
         end
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

### rtl/tensor_network_pair_scorer_top.sv
// Top level of the tensor network pair scorer: weight and partial memories, beat sequencer.
// Depends on tnps_pkg, tnps_chain, tnps_mac.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | start / busy         | req_opcode, req_index, req_value
//  response | rsp_valid (1 cycle)  | rsp_score, rsp_saturated
//
// A weight load or a non-final element leaves the block idle. The last row element
// starts a row pass (partial products, then base terms) and the last column element a
// column pass (neurons, two dense layers, output); both are bound by the single
// multiply-accumulate unit, one beat per cycle outside the drain states.
// busy is high until the pass returns to idle. Synchronous reset clears control only.
// The response strobe cannot be held off by the receiver.
module tensor_network_pair_scorer_top
   import tnps_pkg::*;
#(
   parameter int EMB_DIM        = 16,
   parameter int TENSOR_NEURONS = 16,
   parameter int DENSE_ONE      = 8,
   parameter int DENSE_TWO      = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [12:0]        req_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [15:0]        rsp_score,
   output logic               rsp_saturated
);

   localparam int E       = EMB_DIM;
   localparam int T       = TENSOR_NEURONS;
   localparam int D1      = DENSE_ONE;
   localparam int D2      = DENSE_TWO;
   localparam int ET      = E * T;
   localparam int A_LIN   = ET * E;
   localparam int A_NBIAS = A_LIN + T * 2 * E;
   localparam int A_D1    = A_NBIAS + T;
   localparam int A_D1B   = A_D1 + D1 * T;
   localparam int A_D2    = A_D1B + D1;
   localparam int A_D2B   = A_D2 + D2 * D1;
   localparam int A_D3    = A_D2B + D2;
   localparam int A_D3B   = A_D3 + D2;
   localparam int WORDS   = A_D3B + 1;
   localparam int P_BASE  = ET;
   localparam int P_ACTN  = P_BASE + T;
   localparam int P_H1    = P_ACTN + T;
   localparam int P_H2    = P_H1 + D1;
   localparam int PDEPTH  = P_H2 + D2;
   localparam int WA_W    = $clog2(WORDS);
   localparam int PA_W    = $clog2(PDEPTH);
   localparam int OUT_W   = $clog2(ET + 1);
   localparam int IN_MAX0 = (2 * E > T) ? 2 * E : T;
   localparam int IN_MAX1 = (IN_MAX0 > D1) ? IN_MAX0 : D1;
   localparam int IN_MAX  = (IN_MAX1 > D2) ? IN_MAX1 : D2;
   localparam int IN_W    = $clog2(IN_MAX + 1);
   localparam int E_W     = $clog2(E);

   typedef enum logic [2:0] {
      PH_IDLE, PH_PART, PH_BASE, PH_NEUR, PH_DENSE1, PH_DENSE2, PH_OUT, PH_DRAIN
   } phase_type;

   phase_type         state_ff;
   phase_type         ret_ff;
   logic [1:0]        drain_ff;
   logic              row_pass_ff;
   logic              sat_flag_ff;
   logic [IN_W-1:0]   inner_ff;
   logic [OUT_W-1:0]  outer_ff;

   word_type          wmem [WORDS];
   word_type          pmem [PDEPTH];
   word_type          wmem_q_ff;
   word_type          pmem_q_ff;

   beat_ctrl_type     s1_ctrl_ff;
   asel_type          s1_asel_ff;
   bsel_type          s1_bsel_ff;
   logic [PA_W-1:0]   s1_dest_ff;
   word_type          row_head_ff;
   word_type          col_head_ff;

   logic              rsp_valid_ff;
   logic [15:0]       rsp_score_ff;
   logic              rsp_sat_ff;

   logic              accept;
   logic              elem_ok;
   logic              row_load;
   logic              col_load;
   logic              row_fire;
   logic              col_fire;
   word_type          row_head;
   word_type          col_head;

   beat_ctrl_type     beat;
   asel_type          asel;
   bsel_type          bsel;
   logic              row_shift;
   logic              col_shift;
   logic [31:0]       n;
   logic [31:0]       nm1;
   logic [31:0]       o;
   logic [31:0]       lim;
   logic [31:0]       olim;
   logic [31:0]       wa32;
   logic [31:0]       pa32;
   logic [31:0]       dest32;

   word_type          op_a;
   word_type          op_b;
   mac_res_type       res;
   word_type          res_value;
   logic [PA_W-1:0]   res_dest;
   logic [7:0]        sig_idx;
   logic [31:0]       y_off;

   assign accept   = start && !busy;
   assign elem_ok  = (32'(req_index) < 32'(E));
   assign row_load = accept && (req_opcode == OP_ROW) && elem_ok;
   assign col_load = accept && (req_opcode == OP_COL) && elem_ok;
   assign row_fire = row_load && (32'(req_index) == 32'(E - 1));
   assign col_fire = col_load && (32'(req_index) == 32'(E - 1));

   tnps_chain #(.DEPTH(E)) u_row_chain (
      .clock      (clock),
      .load_en    (row_load),
      .load_pos   (req_index[E_W-1:0]),
      .load_value (req_value),
      .shift_en   (row_shift),
      .head       (row_head)
   );

   tnps_chain #(.DEPTH(E)) u_col_chain (
      .clock      (clock),
      .load_en    (col_load),
      .load_pos   (req_index[E_W-1:0]),
      .load_value (req_value),
      .shift_en   (col_shift),
      .head       (col_head)
   );

   // beat issue: decode the loop counters into addresses and operand sources
   always_comb begin
      beat      = '0;
      asel      = ASEL_ZERO;
      bsel      = BSEL_NONE;
      row_shift = 1'b0;
      col_shift = 1'b0;
      n         = 32'(inner_ff);
      nm1       = n - 32'd1;
      o         = 32'(outer_ff);
      lim       = 32'd0;
      olim      = 32'd1;
      wa32      = '0;
      pa32      = '0;
      dest32    = '0;
      unique case (state_ff)
         PH_PART: begin
            lim = 32'(E); olim = 32'(ET); dest32 = o;
            beat.valid = 1'b1;
            if (n == 32'd0) begin
               beat.init = 1'b1;
            end else begin
               asel = ASEL_WMEM; wa32 = nm1 * 32'(ET) + o;
               bsel = BSEL_ROW; row_shift = 1'b1;
            end
         end
         PH_BASE: begin
            lim = 32'(E); olim = 32'(T); dest32 = 32'(P_BASE) + o;
            beat.valid = 1'b1;
            asel = ASEL_WMEM;
            if (n == 32'd0) begin
               beat.init = 1'b1; wa32 = 32'(A_NBIAS) + o;
            end else begin
               wa32 = 32'(A_LIN) + o * 32'(2 * E) + nm1;
               bsel = BSEL_ROW; row_shift = 1'b1;
            end
         end
         PH_NEUR: begin
            lim = 32'(2 * E); olim = 32'(T); dest32 = 32'(P_ACTN) + o;
            beat.valid = 1'b1; beat.relu = 1'b1;
            if (n == 32'd0) begin
               beat.init = 1'b1; asel = ASEL_PMEM; pa32 = 32'(P_BASE) + o;
            end else if (n <= 32'(E)) begin
               asel = ASEL_PMEM; pa32 = nm1 * 32'(T) + o;
               bsel = BSEL_COL; col_shift = 1'b1;
            end else begin
               asel = ASEL_WMEM; wa32 = 32'(A_LIN) + o * 32'(2 * E) + nm1;
               bsel = BSEL_COL; col_shift = 1'b1;
            end
         end
         PH_DENSE1: begin
            lim = 32'(T); olim = 32'(D1); dest32 = 32'(P_H1) + o;
            beat.valid = 1'b1; beat.relu = 1'b1; asel = ASEL_WMEM;
            if (n == 32'd0) begin
               beat.init = 1'b1; wa32 = 32'(A_D1B) + o;
            end else begin
               wa32 = 32'(A_D1) + o * 32'(T) + nm1;
               bsel = BSEL_PMEM; pa32 = 32'(P_ACTN) + nm1;
            end
         end
         PH_DENSE2: begin
            lim = 32'(D1); olim = 32'(D2); dest32 = 32'(P_H2) + o;
            beat.valid = 1'b1; beat.relu = 1'b1; asel = ASEL_WMEM;
            if (n == 32'd0) begin
               beat.init = 1'b1; wa32 = 32'(A_D2B) + o;
            end else begin
               wa32 = 32'(A_D2) + o * 32'(D1) + nm1;
               bsel = BSEL_PMEM; pa32 = 32'(P_H1) + nm1;
            end
         end
         PH_OUT: begin
            lim = 32'(D2); olim = 32'd1;
            beat.valid = 1'b1; asel = ASEL_WMEM;
            if (n == 32'd0) begin
               beat.init = 1'b1; wa32 = 32'(A_D3B);
            end else begin
               wa32 = 32'(A_D3) + nm1;
               bsel = BSEL_PMEM; pa32 = 32'(P_H2) + nm1;
            end
         end
         PH_IDLE, PH_DRAIN: begin
            beat = '0;
         end
         default: begin
            beat = '0;
         end
      endcase
      beat.last = beat.valid && (n == lim);
      beat.fin  = beat.last && (state_ff == PH_OUT);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PH_IDLE;
         ret_ff      <= PH_IDLE;
         drain_ff    <= '0;
         row_pass_ff <= 1'b0;
         sat_flag_ff <= 1'b0;
         inner_ff    <= '0;
         outer_ff    <= '0;
      end else begin
         unique case (state_ff)
            PH_IDLE: begin
               inner_ff <= '0;
               outer_ff <= '0;
               if (row_fire) begin
                  state_ff    <= PH_PART;
                  row_pass_ff <= 1'b1;
               end else if (col_fire) begin
                  state_ff    <= PH_NEUR;
                  row_pass_ff <= 1'b0;
               end
            end
            PH_DRAIN: begin
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd2) begin
                  drain_ff <= '0;
                  state_ff <= ret_ff;
                  if (ret_ff == PH_IDLE && row_pass_ff) begin
                     sat_flag_ff <= res.sat;
                  end
               end
            end
            default: begin
               if (n == lim) begin
                  inner_ff <= '0;
                  if (o == olim - 32'd1) begin
                     outer_ff <= '0;
                     priority case (state_ff)
                        PH_PART: state_ff <= PH_BASE;
                        PH_NEUR: begin state_ff <= PH_DRAIN; ret_ff <= PH_DENSE1; end
                        PH_DENSE1: begin state_ff <= PH_DRAIN; ret_ff <= PH_DENSE2; end
                        PH_DENSE2: begin state_ff <= PH_DRAIN; ret_ff <= PH_OUT; end
                        default: begin state_ff <= PH_DRAIN; ret_ff <= PH_IDLE; end
                     endcase
                  end else begin
                     outer_ff <= outer_ff + OUT_W'(1);
                  end
               end else begin
                  inner_ff <= inner_ff + IN_W'(1);
               end
            end
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_LOAD) && (32'(req_index) < 32'(WORDS))) begin
         wmem[WA_W'(req_index)] <= req_value;
      end
      wmem_q_ff <= wmem[WA_W'(wa32)];
   end

   always_ff @(posedge clock) begin
      if (res.valid && res.last && !res.fin) begin
         pmem[res_dest] <= res_value;
      end
      pmem_q_ff <= pmem[PA_W'(pa32)];
   end

   // operand fetch stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= beat;
      end
      s1_asel_ff  <= asel;
      s1_bsel_ff  <= bsel;
      s1_dest_ff  <= PA_W'(dest32);
      row_head_ff <= row_head;
      col_head_ff <= col_head;
   end

   always_comb begin
      unique case (s1_asel_ff)
         ASEL_WMEM: op_a = wmem_q_ff;
         ASEL_PMEM: op_a = pmem_q_ff;
         default:   op_a = '0;
      endcase
      unique case (s1_bsel_ff)
         BSEL_ROW:  op_b = row_head_ff;
         BSEL_COL:  op_b = col_head_ff;
         BSEL_PMEM: op_b = pmem_q_ff;
         default:   op_b = '0;
      endcase
   end

   tnps_mac #(.DEST_W(PA_W)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .sat_clear (row_fire || col_fire),
      .in_ctrl   (s1_ctrl_ff),
      .in_dest   (s1_dest_ff),
      .in_a      (op_a),
      .in_b      (op_b),
      .res       (res),
      .res_value (res_value),
      .res_dest  (res_dest)
   );

   // sigmoid lookup, clamped to the table span
   always_comb begin
      y_off = 32'(res_value) + 32'(SIG_HI);
      if (res_value < SIG_LO) begin
         sig_idx = 8'd0;
      end else if (res_value >= SIG_HI) begin
         sig_idx = 8'd255;
      end else begin
         sig_idx = y_off[19:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res.valid && res.fin;
      end
      if (res.valid && res.fin) begin
         rsp_score_ff <= SIG_TABLE[sig_idx];
         rsp_sat_ff   <= sat_flag_ff | res.sat;
      end
   end

   assign busy          = (state_ff != PH_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = rsp_score_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

### rtl/tnps_cell.sv
// One element cell of an embedding chain: holds a Q16.16 word.
// Depends on tnps_pkg.
module tnps_cell
   import tnps_pkg::*;
(
   input  logic     clock,
   input  logic     load_en,
   input  word_type load_value,
   input  logic     shift_en,
   input  word_type next_value,
   output word_type value
);

   word_type value_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         value_ff <= load_value;
      end else if (shift_en) begin
         value_ff <= next_value;
      end
   end

   assign value = value_ff;

endmodule

### rtl/tnps_chain.sv
// Ring of element cells: loaded by position, rotated toward cell 0 one step per use.
// Depends on tnps_pkg and tnps_cell.
module tnps_chain
   import tnps_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     load_en,
   input  logic [$clog2(DEPTH)-1:0] load_pos,
   input  word_type                 load_value,
   input  logic                     shift_en,
   output word_type                 head
);

   word_type cell_value [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      tnps_cell u_cell (
         .clock      (clock),
         .load_en    (load_en && (load_pos == ($clog2(DEPTH))'(g))),
         .load_value (load_value),
         .shift_en   (shift_en),
         .next_value (cell_value[(g + 1) % DEPTH]),
         .value      (cell_value[g])
      );
   end

   assign head = cell_value[0];

endmodule

### rtl/tnps_mac.sv
// Two-stage multiply-accumulate: registered 32x32 product, then floored add with clamp.
// Depends on tnps_pkg.
module tnps_mac
   import tnps_pkg::*;
#(
   parameter int DEST_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sat_clear,
   input  beat_ctrl_type     in_ctrl,
   input  logic [DEST_W-1:0] in_dest,
   input  word_type          in_a,
   input  word_type          in_b,
   output mac_res_type       res,
   output word_type          res_value,
   output logic [DEST_W-1:0] res_dest
);

   beat_ctrl_type        ctrl_ff;
   logic [DEST_W-1:0]    dest_ff;
   word_type             init_ff;
   logic signed [63:0]   prod_ff;
   word_type             acc_ff;
   logic                 sat_ff;

   logic signed [48:0]   sum_wide;
   word_type             sum;
   logic                 step_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= in_ctrl;
      end
      dest_ff <= in_dest;
      init_ff <= in_a;
      prod_ff <= in_a * in_b;
   end

   always_comb begin
      sum_wide = {{17{acc_ff[31]}}, acc_ff} + {prod_ff[63], prod_ff[63:16]};
      step_sat = 1'b0;
      if (ctrl_ff.init) begin
         sum = init_ff;
      end else if (sum_wide[48:31] != {18{sum_wide[48]}}) begin
         step_sat = ctrl_ff.valid;
         sum      = sum_wide[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum = sum_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || sat_clear) begin
         sat_ff <= 1'b0;
      end else if (step_sat) begin
         sat_ff <= 1'b1;
      end
      if (ctrl_ff.valid) begin
         acc_ff <= sum;
      end
   end

   assign res.valid = ctrl_ff.valid;
   assign res.last  = ctrl_ff.last;
   assign res.fin   = ctrl_ff.fin;
   assign res.sat   = sat_ff | step_sat;
   assign res_value = (ctrl_ff.relu && sum[31]) ? '0 : sum;
   assign res_dest  = dest_ff;

endmodule

### rtl/tnps_checker.sv
// Port-level checks of the pair scorer and the bind that attaches them.
// Depends on tnps_pkg and tensor_network_pair_scorer_top.
module tnps_checker
   import tnps_pkg::*;
#(
   parameter int EMB_DIM = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic [12:0] req_index,
   input logic        rsp_valid
);

   // one score per column, never in back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a scoring pass");

   a_col_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_COL && 32'(req_index) == 32'(EMB_DIM - 1))
      |=> busy)
      else $error("last column element did not start a pass");

   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_LOAD) |=> !busy)
      else $error("weight load transaction stalled the block");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind tensor_network_pair_scorer_top tnps_checker #(.EMB_DIM(EMB_DIM)) u_tnps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .req_index  (req_index),
   .rsp_valid  (rsp_valid)
);
